/* src/spo_pkg.sv */
package spo_pkg;

	// default sizes
	localparam int NUM_PATCHES_DEF = 1024;
	localparam int MAX_DEGREE_DEF  = 32;

	// fixed field widths
	localparam int PATCH_FW  = 10;
	localparam int SLOT_FW   = 5;
	localparam int NB_FW     = 10;
	localparam int DEG_FW    = 6;
	localparam int PROB_W    = 16;
	localparam int VISITS_W  = 16;
	localparam int Q16_W     = 17;

	localparam logic [Q16_W-1:0] Q16_ONE = 17'h10000;
	localparam logic [VISITS_W-1:0] VISITS_MAX = 16'hFFFF;

	// register reset values (0.4 and 0.8)
	localparam logic [PROB_W-1:0] EXTINCTION_RST = 16'd26214;
	localparam logic [PROB_W-1:0] STAY_EMPTY_RST = 16'd52429;

	// register indexes
	localparam logic CFG_EXTINCTION = 1'b0;
	localparam logic CFG_STAY_EMPTY = 1'b1;

	// request codes
	typedef enum logic [1:0] {
		REQ_LOAD_NB  = 2'd0,
		REQ_SET_DEG  = 2'd1,
		REQ_UPDATE   = 2'd2,
		REQ_END_SWP  = 2'd3
	} req_type_t;

	// write enables toward the storage
	typedef struct packed {
		logic nt;
		logic deg;
		logic bank_a;
		logic bank_b;
		logic vis;
	} mem_we_t;

	// power unit control and status
	typedef struct packed {
		logic start;
	} pow_ctl_t;

	typedef struct packed {
		logic busy;
	} pow_stat_t;

endpackage

/* src/spo_req_if.sv */
interface spo_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [9:0]  patch;
	logic [4:0]  slot;
	logic [9:0]  neighbor;
	logic [5:0]  degree;
	logic        start_present;
	logic [15:0] draw;

	modport source (output valid, req_type, patch, slot, neighbor, degree, start_present,
		draw, input ready);
	modport sink (input valid, req_type, patch, slot, neighbor, degree, start_present,
		draw, output ready);
endinterface

/* src/spo_res_if.sv */
interface spo_res_if;
	logic        valid;
	logic        ready;
	logic        present;
	logic [5:0]  occupied_neighbors;
	logic [15:0] visits;
	logic        status;

	modport source (output valid, present, occupied_neighbors, visits, status,
		input ready);
	modport sink (input valid, present, occupied_neighbors, visits, status,
		output ready);
endinterface

/* src/spo_cfg_if.sv */
interface spo_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/spo_mem.sv */
module spo_mem #(
	parameter int NUM_PATCHES = spo_pkg::NUM_PATCHES_DEF,
	parameter int MAX_DEGREE  = spo_pkg::MAX_DEGREE_DEF,
	localparam int PW  = (NUM_PATCHES > 1) ? $clog2(NUM_PATCHES) : 1,
	localparam int CW  = $clog2(MAX_DEGREE + 1),
	localparam int NTD = NUM_PATCHES * MAX_DEGREE,
	localparam int NTW = (NTD > 1) ? $clog2(NTD) : 1
) (
	input  logic                        clk,
	input  spo_pkg::mem_we_t            we,
	input  logic [NTW-1:0]              nt_addr,
	input  logic [spo_pkg::NB_FW-1:0]   nt_wd,
	output logic [spo_pkg::NB_FW-1:0]   nt_rd,
	input  logic [PW-1:0]               p_addr,
	input  logic [CW-1:0]               deg_wd,
	output logic [CW-1:0]               deg_rd,
	input  logic [spo_pkg::VISITS_W-1:0] vis_wd,
	output logic [spo_pkg::VISITS_W-1:0] vis_rd,
	input  logic [PW-1:0]               b_addr,
	input  logic                        b_wd,
	output logic                        a_rd,
	output logic                        b_rd
);
	import spo_pkg::*;

	logic [NB_FW-1:0]    nt_mem  [NTD];
	logic [CW-1:0]       deg_mem [NUM_PATCHES];
	logic [VISITS_W-1:0] vis_mem [NUM_PATCHES];
	logic                a_mem   [NUM_PATCHES];
	logic                b_mem   [NUM_PATCHES];

	// neighbor table
	always_ff @(posedge clk) begin
		if (we.nt) nt_mem[nt_addr] <= nt_wd;
		nt_rd <= nt_mem[nt_addr];
	end

	// degree table
	always_ff @(posedge clk) begin
		if (we.deg) deg_mem[p_addr] <= deg_wd;
		deg_rd <= deg_mem[p_addr];
	end

	// visit counts
	always_ff @(posedge clk) begin
		if (we.vis) vis_mem[p_addr] <= vis_wd;
		vis_rd <= vis_mem[p_addr];
	end

	// occupancy banks
	always_ff @(posedge clk) begin
		if (we.bank_a) a_mem[b_addr] <= b_wd;
		a_rd <= a_mem[b_addr];
	end

	always_ff @(posedge clk) begin
		if (we.bank_b) b_mem[b_addr] <= b_wd;
		b_rd <= b_mem[b_addr];
	end

endmodule

/* src/spo_pow.sv */
module spo_pow #(
	parameter int MAX_DEGREE = spo_pkg::MAX_DEGREE_DEF,
	localparam int CW = $clog2(MAX_DEGREE + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spo_pkg::pow_ctl_t           ctl,
	input  logic [CW-1:0]               count,
	input  logic [spo_pkg::PROB_W-1:0]  stay,
	output spo_pkg::pow_stat_t          stat,
	output logic [spo_pkg::Q16_W-1:0]   s
);
	import spo_pkg::*;

	logic [CW-1:0]           cnt_q;
	logic [Q16_W-1:0]        s_q;
	logic [Q16_W+PROB_W-1:0] prod;

	// one truncating q1.16 by q0.16 multiply per cycle while busy
	assign prod = s_q * stay;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			s_q   <= Q16_ONE;
		end else if (ctl.start) begin
			cnt_q <= count;
			s_q   <= Q16_ONE;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
			s_q   <= prod[Q16_W+PROB_W-1:PROB_W];
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign s = s_q;

endmodule

/* src/stochastic_patch_occupancy_step_top.sv */
// load, degree and sweep-end items pass from accept through S_EXEC to S_OUT, where the result is valid
// update of an occupied patch passes S_EXEC, S_CHK and S_WB to S_OUT; an empty patch adds S_WALK,
// d its degree (neighbor walk, one table read per cycle), and S_POW, x occupied neighbors
// (one multiply per cycle), between S_CHK and S_WB
// one item at a time; the next is accepted after the result is taken
// reset: clearing pass over all patches (one patch per cycle) before the first item is accepted
module stochastic_patch_occupancy_step_top #(
	parameter int NUM_PATCHES = spo_pkg::NUM_PATCHES_DEF,
	parameter int MAX_DEGREE  = spo_pkg::MAX_DEGREE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	spo_req_if.sink   req,
	spo_res_if.source res,
	spo_cfg_if.sink   cfg
);
	import spo_pkg::*;

	localparam int PW  = (NUM_PATCHES > 1) ? $clog2(NUM_PATCHES) : 1;
	localparam int CW  = $clog2(MAX_DEGREE + 1);
	localparam int NTD = NUM_PATCHES * MAX_DEGREE;
	localparam int NTW = (NTD > 1) ? $clog2(NTD) : 1;
	localparam logic [16:0] NP_L = 17'(NUM_PATCHES);
	localparam logic [8:0]  MD_L = 9'(MAX_DEGREE);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_CHK, S_WALK, S_POW, S_WB, S_OUT
	} state_t;

	state_t state_q;

	// registers
	logic [PROB_W-1:0]   ext_q, stay_q;
	logic                cur_q;
	logic [PW-1:0]       clr_q;
	req_type_t           type_q;
	logic [PATCH_FW-1:0] patch_q;
	logic [SLOT_FW-1:0]  slot_q;
	logic [NB_FW-1:0]    nb_q;
	logic [DEG_FW-1:0]   deg_q;
	logic                start_q;
	logic [PROB_W-1:0]   draw_q;
	logic [CW-1:0]       d_q, v_q, cnt_q;
	logic                nt_vld_s1, bk_vld_s2;
	logic                now_q;
	logic [VISITS_W-1:0] vis_q;
	logic                res_present_q, res_status_q;
	logic [DEG_FW-1:0]   res_occn_q;
	logic [VISITS_W-1:0] res_vis_q;

	// storage and power unit wiring
	mem_we_t             we;
	logic [NTW-1:0]      nt_addr, nt_base;
	logic [NB_FW-1:0]    nt_rd;
	logic [PW-1:0]       p_addr, b_addr, patch_idx;
	logic [CW-1:0]       deg_wd, deg_rd;
	logic [VISITS_W-1:0] vis_wd, vis_rd, vis_inc;
	logic                b_wd, a_rd, b_rd, old_bit;
	pow_ctl_t            pow_ctl;
	pow_stat_t           pow_stat;
	logic [Q16_W-1:0]    pow_s;
	logic                bad, walk_issue, walk_done, nb_ok;

	spo_mem #(.NUM_PATCHES(NUM_PATCHES), .MAX_DEGREE(MAX_DEGREE)) u_mem (
		.clk(clk), .we(we), .nt_addr(nt_addr), .nt_wd(nb_q), .nt_rd(nt_rd),
		.p_addr(p_addr), .deg_wd(deg_wd), .deg_rd(deg_rd), .vis_wd(vis_wd),
		.vis_rd(vis_rd), .b_addr(b_addr), .b_wd(b_wd), .a_rd(a_rd), .b_rd(b_rd)
	);

	spo_pow #(.MAX_DEGREE(MAX_DEGREE)) u_pow (
		.clk(clk), .arst_n(arst_n), .ctl(pow_ctl), .count(cnt_q), .stay(stay_q),
		.stat(pow_stat), .s(pow_s)
	);

	// field checks on the held item
	always_comb begin
		bad = (17'(patch_q) >= NP_L);
		case (type_q)
			REQ_LOAD_NB: bad = bad || (9'(slot_q) >= MD_L) || (17'(nb_q) >= NP_L);
			REQ_SET_DEG: bad = bad || (9'(deg_q) > MD_L);
			REQ_UPDATE:  bad = bad;
			default:     bad = 1'b0;
		endcase
	end

	assign patch_idx  = PW'(patch_q);
	assign nt_base    = NTW'(patch_q) * NTW'(MAX_DEGREE);
	assign old_bit    = cur_q ? b_rd : a_rd;
	assign walk_issue = (v_q < d_q);
	assign walk_done  = !walk_issue && !nt_vld_s1 && !bk_vld_s2;
	assign nb_ok      = (17'(nt_rd) < NP_L);
	assign vis_inc    = (vis_q == VISITS_MAX) ? vis_q : vis_q + 1'b1;

	// address and write steering
	always_comb begin
		we      = '0;
		nt_addr = nt_base + NTW'(slot_q);
		p_addr  = patch_idx;
		b_addr  = patch_idx;
		deg_wd  = CW'(deg_q);
		vis_wd  = vis_inc;
		b_wd    = start_q;
		pow_ctl.start = 1'b0;
		case (state_q)
			S_CLEAR: begin
				p_addr = clr_q;
				b_addr = clr_q;
				deg_wd = '0;
				vis_wd = '0;
				b_wd   = 1'b1;
				we     = '{nt: 1'b0, deg: 1'b1, bank_a: 1'b1, bank_b: 1'b1, vis: 1'b1};
			end
			S_EXEC: begin
				if (!bad && type_q == REQ_LOAD_NB) we.nt = 1'b1;
				if (!bad && type_q == REQ_SET_DEG) begin
					we.deg    = 1'b1;
					we.bank_a = !cur_q;
					we.bank_b = cur_q;
				end
			end
			S_WALK: begin
				nt_addr = nt_base + NTW'(v_q);
				b_addr  = PW'(nt_rd);
				pow_ctl.start = walk_done;
			end
			S_WB: begin
				b_wd      = now_q;
				we.bank_a = cur_q;
				we.bank_b = !cur_q;
				we.vis    = now_q;
			end
			default: ;
		endcase
	end

	// configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q  <= EXTINCTION_RST;
			stay_q <= STAY_EMPTY_RST;
		end else if (cfg.valid) begin
			if (cfg.index == CFG_EXTINCTION) ext_q <= cfg.data;
			else stay_q <= cfg.data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			cur_q     <= 1'b0;
			nt_vld_s1 <= 1'b0;
			bk_vld_s2 <= 1'b0;
			v_q       <= '0;
			d_q       <= '0;
			cnt_q     <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == PW'(NUM_PATCHES - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req.valid) begin
						type_q  <= req_type_t'(req.req_type);
						patch_q <= req.patch;
						slot_q  <= req.slot;
						nb_q    <= req.neighbor;
						deg_q   <= req.degree;
						start_q <= req.start_present;
						draw_q  <= req.draw;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					res_present_q <= 1'b0;
					res_occn_q    <= '0;
					res_vis_q     <= '0;
					res_status_q  <= bad;
					state_q       <= S_OUT;
					if (type_q == REQ_END_SWP) cur_q <= !cur_q;
					else if (!bad && type_q == REQ_SET_DEG) res_present_q <= start_q;
					else if (!bad && type_q == REQ_UPDATE) state_q <= S_CHK;
				end
				S_CHK: begin
					vis_q     <= vis_rd;
					cnt_q     <= '0;
					v_q       <= '0;
					nt_vld_s1 <= 1'b0;
					bk_vld_s2 <= 1'b0;
					if (old_bit) begin
						now_q   <= !(draw_q < ext_q);
						state_q <= S_WB;
					end else begin
						d_q     <= deg_rd;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (walk_issue) v_q <= v_q + 1'b1;
					nt_vld_s1 <= walk_issue;
					bk_vld_s2 <= nt_vld_s1 && nb_ok;
					if (bk_vld_s2 && old_bit) cnt_q <= cnt_q + 1'b1;
					if (walk_done) state_q <= S_POW;
				end
				S_POW: begin
					if (!pow_stat.busy) begin
						now_q   <= ({1'b0, draw_q} < (Q16_ONE - pow_s));
						state_q <= S_WB;
					end
				end
				S_WB: begin
					res_present_q <= now_q;
					res_occn_q    <= DEG_FW'(cnt_q);
					res_vis_q     <= now_q ? vis_inc : vis_q;
					res_status_q  <= 1'b0;
					state_q       <= S_OUT;
				end
				S_OUT: begin
					if (res.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ports
	assign req.ready              = (state_q == S_IDLE);
	assign res.valid              = (state_q == S_OUT);
	assign res.present            = res_present_q;
	assign res.occupied_neighbors = res_occn_q;
	assign res.visits             = res_vis_q;
	assign res.status             = res_status_q;

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && res.valid)) else $error("accept while result pending");
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !req.ready) else $error("accept during clearing pass");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> (cnt_q <= d_q)) else $error("neighbor count exceeds degree");
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status) |-> (!res.present && res.visits == '0))
		else $error("rejected item carries data");

endmodule

/* tb/stochastic_patch_occupancy_step_top_tb.sv */
`timescale 1ns / 100ps

module stochastic_patch_occupancy_step_top_tb;
	import spo_pkg::*;

	typedef struct {
		req_type_t   rt;
		logic [9:0]  patch;
		logic [4:0]  slot;
		logic [9:0]  neighbor;
		logic [5:0]  degree;
		logic        start_present;
		logic [15:0] draw;
	} patch_req_t;

	typedef struct {
		logic        present;
		logic [5:0]  occn;
		logic [15:0] visits;
		logic        status;
	} patch_res_t;

	logic clk;
	logic arst_n;

	spo_req_if req ();
	spo_res_if res ();
	spo_cfg_if cfg ();

	stochastic_patch_occupancy_step_top DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.res   (res.source),
		.cfg   (cfg.sink)
	);

	// mirror of the block state
	logic [9:0]  nbr_tab [0:32767];
	bit          nbr_written [0:32767];
	logic [5:0]  deg_tab [0:1023];
	bit          occ [2][0:1023];
	logic [15:0] visit_tab [0:1023];
	bit          cur_bank;
	logic [15:0] ext_prob;
	logic [15:0] stay_prob;

	patch_res_t  pending_res [$];
	int          fail_cnt;
	bit          idle_en;
	int          hold_cnt;
	int          stall_cnt;
	int          ws [32];

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// timeout
	initial begin
		#20ms;
		$display("stochastic_patch_occupancy_step_top_tb failed");
		$finish;
	end

	// expected result of one item, updates the mirror
	function automatic patch_res_t occupancy_predict(patch_req_t it);
		patch_res_t  r;
		logic [32:0] s;
		logic [5:0]  cnt;
		bit          now;
		int          base;
		r = '{default: '0};
		base = int'(it.patch) * 32;
		case (it.rt)
			REQ_END_SWP: cur_bank = ~cur_bank;
			REQ_LOAD_NB: begin
				nbr_tab[base + it.slot] = it.neighbor;
				nbr_written[base + it.slot] = 1'b1;
			end
			REQ_SET_DEG: begin
				if (it.degree > 6'd32) begin
					r.status = 1'b1;
				end else begin
					deg_tab[it.patch] = it.degree;
					occ[cur_bank][it.patch] = it.start_present;
					r.present = it.start_present;
				end
			end
			default: begin
				cnt = '0;
				if (occ[cur_bank][it.patch]) begin
					now = !(it.draw < ext_prob);
				end else begin
					for (int v = 0; v < deg_tab[it.patch]; v++)
						if (occ[cur_bank][nbr_tab[base + v]])
							cnt++;
					s = 33'h10000;
					for (int v = 0; v < cnt; v++)
						s = (s * stay_prob) >> 16;
					now = ({17'd0, it.draw} < (33'h10000 - s));
				end
				occ[~cur_bank][it.patch] = now;
				if (now && visit_tab[it.patch] != VISITS_MAX)
					visit_tab[it.patch]++;
				r.present = now;
				r.occn = cnt;
				r.visits = visit_tab[it.patch];
			end
		endcase
		return r;
	endfunction

	// all neighbor entries below the degree were loaded
	function automatic bit walk_defined(logic [9:0] p);
		for (int v = 0; v < deg_tab[p]; v++)
			if (!nbr_written[int'(p) * 32 + v])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic int loaded_prefix(logic [9:0] p);
		int n;
		n = 0;
		while (n < 32 && nbr_written[int'(p) * 32 + n])
			n++;
		return n;
	endfunction

	function automatic patch_req_t rand_fields(req_type_t rt);
		patch_req_t it;
		it.rt = rt;
		it.patch = 10'($urandom);
		it.slot = 5'($urandom);
		it.neighbor = 10'($urandom);
		it.degree = 6'($urandom);
		it.start_present = 1'($urandom);
		it.draw = 16'($urandom);
		return it;
	endfunction

	// send one item, called at a falling edge
	task automatic send_item(patch_req_t it);
		if (idle_en && $urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 19)) @(negedge clk);
		req.req_type = it.rt;
		req.patch = it.patch;
		req.slot = it.slot;
		req.neighbor = it.neighbor;
		req.degree = it.degree;
		req.start_present = it.start_present;
		req.draw = it.draw;
		req.valid = 1'b1;
		do @(posedge clk); while (!req.ready);
		pending_res.push_back(occupancy_predict(it));
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic send_load(logic [9:0] p, logic [4:0] sl, logic [9:0] nb);
		patch_req_t it;
		it = rand_fields(REQ_LOAD_NB);
		it.patch = p;
		it.slot = sl;
		it.neighbor = nb;
		send_item(it);
	endtask

	task automatic send_deg(logic [9:0] p, logic [5:0] d, logic sp);
		patch_req_t it;
		it = rand_fields(REQ_SET_DEG);
		it.patch = p;
		it.degree = d;
		it.start_present = sp;
		send_item(it);
	endtask

	// update, made defined first if the walk would read unloaded entries
	task automatic send_update(logic [9:0] p, logic [15:0] dr);
		patch_req_t it;
		if (!walk_defined(p))
			send_deg(p, 6'(loaded_prefix(p)), 1'($urandom));
		it = rand_fields(REQ_UPDATE);
		it.patch = p;
		it.draw = dr;
		send_item(it);
	endtask

	task automatic send_sweep();
		send_item(rand_fields(REQ_END_SWP));
	endtask

	task automatic wait_drained();
		wait (pending_res.size() == 0);
		@(negedge clk);
	endtask

	// register write while idle
	task automatic cfg_write(logic idx, logic [15:0] val);
		wait_drained();
		repeat (80) @(negedge clk);
		cfg.index = idx;
		cfg.data = val;
		cfg.valid = 1'b1;
		do @(posedge clk); while (!cfg.ready);
		if (idx == CFG_EXTINCTION)
			ext_prob = val;
		else
			stay_prob = val;
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// result side stalls
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			res.ready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			res.ready <= 1'b0;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			stall_cnt <= $urandom_range(1, 19) - 1;
			res.ready <= 1'b0;
		end else begin
			res.ready <= 1'b1;
		end
	end

	// result compare
	always @(posedge clk) begin
		patch_res_t e;
		if (arst_n && res.valid && res.ready) begin
			if (pending_res.size() == 0) begin
				$error("result with no item pending");
				fail_cnt++;
			end else begin
				e = pending_res.pop_front();
				if (res.present !== e.present) begin
					$error("present exp %0d got %0d", e.present, res.present);
					fail_cnt++;
				end
				if (res.occupied_neighbors !== e.occn) begin
					$error("occupied_neighbors exp %0d got %0d", e.occn,
						res.occupied_neighbors);
					fail_cnt++;
				end
				if (res.visits !== e.visits) begin
					$error("visits exp %0d got %0d", e.visits, res.visits);
					fail_cnt++;
				end
				if (res.status !== e.status) begin
					$error("status exp %0d got %0d", e.status, res.status);
					fail_cnt++;
				end
			end
		end
	end

	// full neighbor list on the top patch, boundary entries
	task automatic test_graph_load();
		for (int s = 0; s < 32; s++)
			send_load(10'd1023, 5'(s), (s == 0) ? 10'd0 : (s == 31) ? 10'd1023 : 10'(s));
		send_load(10'd0, 5'd31, 10'd1023);
		send_deg(10'd1023, 6'd32, 1'b0);
		send_deg(10'd0, 6'd0, 1'b0);
	endtask

	task automatic test_rejects();
		send_deg(10'd5, 6'd33, 1'b1);
		send_deg(10'd5, 6'd63, 1'b0);
	endtask

	task automatic test_updates();
		send_update(10'd1023, 16'hFFFF);
		send_update(10'd0, 16'd0);
		send_update(10'd5, 16'd0);
		send_update(10'd6, 16'hFFFF);
		send_sweep();
		send_update(10'd1023, 16'd0);
		send_sweep();
	endtask

	task automatic test_config_extremes();
		cfg_write(CFG_EXTINCTION, 16'hFFFF);
		cfg_write(CFG_STAY_EMPTY, 16'd0);
		send_update(10'd7, 16'hFFFF);
		send_update(10'd7, 16'hFFFE);
		send_deg(10'd1023, 6'd32, 1'b0);
		send_update(10'd1023, 16'hFFFF);
		cfg_write(CFG_STAY_EMPTY, 16'hFFFF);
		send_deg(10'd1023, 6'd32, 1'b0);
		send_update(10'd1023, 16'd0);
		send_update(10'd1023, 16'hFFFF);
		cfg_write(CFG_EXTINCTION, 16'd0);
		send_update(10'd8, 16'd0);
		cfg_write(CFG_EXTINCTION, EXTINCTION_RST);
		cfg_write(CFG_STAY_EMPTY, STAY_EMPTY_RST);
	endtask

	// random graph on a working set, then a mixed stream
	task automatic test_random(int n);
		int d;
		int k;
		logic [9:0] p;
		for (int i = 2; i < 32; i++) begin
			if (ws[i] == 0) begin
				ws[i] = $urandom_range(1, 1022);
				d = ($urandom_range(0, 9) == 0) ? 32 : $urandom_range(0, 5);
				for (int s = 0; s < d; s++)
					send_load(10'(ws[i]), 5'(s), ($urandom_range(0, 4) == 0) ?
						10'($urandom) : 10'(ws[$urandom_range(0, 31)]));
				send_deg(10'(ws[i]), 6'(d), 1'($urandom));
			end
		end
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 99);
			p = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'(ws[$urandom_range(0, 31)]);
			if (k < 55)
				send_update(p, 16'($urandom));
			else if (k < 70)
				send_load(p, 5'($urandom), ($urandom_range(0, 4) == 0) ?
					10'($urandom) : 10'(ws[$urandom_range(0, 31)]));
			else if (k < 85)
				send_deg(p, ($urandom_range(0, 5) == 0) ? 6'($urandom_range(33, 63)) :
					6'($urandom_range(0, loaded_prefix(p))), 1'($urandom));
			else if (k < 95)
				send_sweep();
			else
				send_update(p, ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF);
		end
	endtask

	// long result hold-off, a pause until drained, then a short random stream
	task automatic test_backpressure();
		hold_cnt = 400;
		for (int i = 0; i < 6; i++)
			send_update(10'(ws[$urandom_range(0, 31)]), 16'($urandom));
		wait_drained();
		test_random(10);
	endtask

	// occupied patch kept alive so its count climbs every update
	task automatic test_visit_count();
		cfg_write(CFG_EXTINCTION, 16'd0);
		send_deg(10'd777, 6'd0, 1'b1);
		for (int i = 0; i < 24; i++)
			send_update(10'd777, 16'($urandom));
		cfg_write(CFG_EXTINCTION, EXTINCTION_RST);
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.req_type = REQ_LOAD_NB;
		req.patch = '0;
		req.slot = '0;
		req.neighbor = '0;
		req.degree = '0;
		req.start_present = 1'b0;
		req.draw = '0;
		cfg.valid = 1'b0;
		cfg.index = CFG_EXTINCTION;
		cfg.data = '0;
		res.ready = 1'b0;
		fail_cnt = 0;
		idle_en = 1'b1;
		hold_cnt = 0;
		stall_cnt = 0;
		cur_bank = 1'b0;
		ext_prob = EXTINCTION_RST;
		stay_prob = STAY_EMPTY_RST;
		for (int i = 0; i < 1024; i++) begin
			deg_tab[i] = '0;
			occ[0][i] = 1'b1;
			occ[1][i] = 1'b1;
			visit_tab[i] = '0;
		end
		for (int i = 0; i < 32768; i++) begin
			nbr_tab[i] = '0;
			nbr_written[i] = 1'b0;
		end
		foreach (ws[i])
			ws[i] = 0;
		ws[1] = 1023;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_graph_load();
		test_rejects();
		test_updates();
		test_config_extremes();
		test_random(200);
		test_backpressure();
		cfg_write(CFG_EXTINCTION, 16'd9000);
		cfg_write(CFG_STAY_EMPTY, 16'd20000);
		test_random(150);
		cfg_write(CFG_EXTINCTION, EXTINCTION_RST);
		cfg_write(CFG_STAY_EMPTY, STAY_EMPTY_RST);
		idle_en = 1'b0;
		test_visit_count();
		test_random(100);

		wait (pending_res.size() == 0);
		repeat (100) @(posedge clk);
		if (fail_cnt == 0 && pending_res.size() == 0)
			$display("stochastic_patch_occupancy_step_top_tb passed");
		else
			$display("stochastic_patch_occupancy_step_top_tb failed");
		$finish;
	end

endmodule
